[hw/rtl/bpc_pkg.sv]
// Package for the button press classifier: phase and event codes,
// configuration register indexes, the register struct and the reset values.
// No dependencies.
package bpc_pkg;

  localparam int unsigned TimeBitsDefault = 24;

  localparam int unsigned DebWidth  = 16;
  localparam int unsigned WinWidth  = 24;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 24;

  localparam logic [DebWidth-1:0] DebounceTicksRst    = 16'd20;
  localparam logic [WinWidth-1:0] LongPressTicksRst   = 24'd1000;
  localparam logic [WinWidth-1:0] SecondPressTicksRst = 24'd400;

  typedef enum logic [3:0] {
    PhIdle     = 4'd0,
    PhDebPress = 4'd1,
    PhSingle   = 4'd2,
    PhLongWait = 4'd3,
    PhLong     = 4'd4,
    PhWaitRel  = 4'd5,
    PhSecWait  = 4'd6,
    PhSecDeb   = 4'd7,
    PhDouble   = 4'd8,
    PhDebRel   = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvSingle = 2'd1,
    EvLong   = 2'd2,
    EvDouble = 2'd3
  } press_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounceTicks    = 2'd0,
    CfgLongPressTicks   = 2'd1,
    CfgSecondPressTicks = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DebWidth-1:0] debounce_ticks;
    logic [WinWidth-1:0] long_press_ticks;
    logic [WinWidth-1:0] second_press_ticks;
  } cfg_t;

endpackage

[hw/rtl/bpc_in_if.sv]
// Tick input channel of the button press classifier.
// Depends on nothing.
interface bpc_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

[hw/rtl/bpc_out_if.sv]
// Result channel of the button press classifier.
// Depends on nothing.
interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_event;
  logic [3:0] phase_code;
  logic       phase_changed;

  modport source (output valid, output press_event, output phase_code,
                  output phase_changed, input ready);
  modport sink   (input valid, input press_event, input phase_code,
                  input phase_changed, output ready);
endinterface

[hw/rtl/bpc_cfg_if.sv]
// Configuration write channel of the button press classifier.
// Depends on bpc_pkg for index and data widths.
interface bpc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bpc_pkg::CfgIdxW-1:0]   index;
  logic [bpc_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/bpc_cfg_regs.sv]
// Configuration registers of the button press classifier.
// Depends on bpc_pkg and bpc_cfg_if.
module bpc_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  bpc_cfg_if.sink          cfg_i,
  output bpc_pkg::cfg_t    cfg_o
);

  bpc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        bpc_pkg::CfgDebounceTicks: begin
          cfg_d.debounce_ticks = cfg_i.data[bpc_pkg::DebWidth-1:0];
        end
        bpc_pkg::CfgLongPressTicks: begin
          cfg_d.long_press_ticks = cfg_i.data[bpc_pkg::WinWidth-1:0];
        end
        bpc_pkg::CfgSecondPressTicks: begin
          cfg_d.second_press_ticks = cfg_i.data[bpc_pkg::WinWidth-1:0];
        end
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks     <= bpc_pkg::DebounceTicksRst;
      cfg_q.long_press_ticks   <= bpc_pkg::LongPressTicksRst;
      cfg_q.second_press_ticks <= bpc_pkg::SecondPressTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/button_press_classifier.sv]
// Button press classifier: debounced single / long / double press detector.
// The result register loads on each tick transfer. Throughput: one tick per
// cycle unless the sink stalls; it is refilled in the same cycle it drains.
// Reset (async, active low): phase idle, counters zero, no result pending,
// registers at 20 / 1000 / 400 ticks.
// Depends on bpc_pkg, bpc_in_if, bpc_out_if, bpc_cfg_if, bpc_cfg_regs.
module button_press_classifier #(
  parameter int unsigned TimeBits = bpc_pkg::TimeBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpc_in_if.sink    item_i,
  bpc_out_if.source result_o,
  bpc_cfg_if.sink   cfg_i
);

  // Compare width covers both the timer and the 24-bit window registers.
  localparam int unsigned CmpW =
      (TimeBits > bpc_pkg::WinWidth) ? TimeBits : bpc_pkg::WinWidth;

  bpc_pkg::cfg_t cfg;

  bpc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // ---------------------------------------------------------------------
  // Handshake: a tick is taken whenever the result register is empty or
  // being drained this cycle.
  // ---------------------------------------------------------------------
  logic item_xfer;
  assign item_i.ready = !result_o.valid || result_o.ready;
  assign item_xfer    = item_i.valid && item_i.ready;

  // ---------------------------------------------------------------------
  // Classifier state
  // ---------------------------------------------------------------------
  bpc_pkg::phase_e                  phase_q, phase_d;
  logic [bpc_pkg::DebWidth-1:0]     dbc_q, dbc_d;
  logic [TimeBits-1:0]              elapsed_q, elapsed_d;

  logic                pressed;
  logic                dbc_done;
  logic [bpc_pkg::DebWidth-1:0] dbc_adv;
  logic                restart;
  logic [CmpW-1:0]     elapsed_ext;
  logic                over_long;
  logic                over_second;
  bpc_pkg::press_event_e event_code;

  assign pressed     = !item_i.pin_level;
  assign elapsed_ext = CmpW'(elapsed_q);
  assign over_long   = elapsed_ext > CmpW'(cfg.long_press_ticks);
  assign over_second = elapsed_ext > CmpW'(cfg.second_press_ticks);

  // Debounce: count up to debounce_ticks, then leave and clear.
  assign dbc_done = !(dbc_q < cfg.debounce_ticks);
  assign dbc_adv  = dbc_done ? '0 : dbc_q + 1'b1;

  // Next phase and counters
  always_comb begin
    phase_d = phase_q;
    dbc_d   = dbc_q;
    restart = 1'b0;
    case (phase_q)
      bpc_pkg::PhIdle: begin
        if (pressed) phase_d = bpc_pkg::PhDebPress;
      end
      bpc_pkg::PhDebPress: begin
        dbc_d = dbc_adv;
        if (dbc_done) begin
          restart = 1'b1;   // first press accepted: timer starts here
          phase_d = bpc_pkg::PhLongWait;
        end
      end
      bpc_pkg::PhSingle: begin
        phase_d = bpc_pkg::PhWaitRel;
      end
      bpc_pkg::PhLongWait: begin
        if (!pressed)      phase_d = bpc_pkg::PhSecWait;
        else if (over_long) phase_d = bpc_pkg::PhLong;
      end
      bpc_pkg::PhLong: begin
        phase_d = bpc_pkg::PhWaitRel;
      end
      bpc_pkg::PhWaitRel: begin
        if (!pressed) phase_d = bpc_pkg::PhDebRel;
      end
      bpc_pkg::PhSecWait: begin
        // window expiry wins over a press on the same tick
        if (over_second)  phase_d = bpc_pkg::PhSingle;
        else if (pressed) phase_d = bpc_pkg::PhSecDeb;
      end
      bpc_pkg::PhSecDeb: begin
        dbc_d = dbc_adv;
        if (dbc_done) phase_d = bpc_pkg::PhDouble;
      end
      bpc_pkg::PhDouble: begin
        phase_d = bpc_pkg::PhWaitRel;
      end
      bpc_pkg::PhDebRel: begin
        dbc_d = dbc_adv;
        if (dbc_done) phase_d = bpc_pkg::PhIdle;
      end
      default: begin
        phase_d = bpc_pkg::PhIdle;
      end
    endcase
  end

  // Event output: each event phase reports its code for one tick
  always_comb begin
    case (phase_q)
      bpc_pkg::PhSingle: event_code = bpc_pkg::EvSingle;
      bpc_pkg::PhLong:   event_code = bpc_pkg::EvLong;
      bpc_pkg::PhDouble: event_code = bpc_pkg::EvDouble;
      default:           event_code = bpc_pkg::EvNone;
    endcase
  end

  // Elapsed timer: compared above with the old value, then cleared or
  // incremented, saturating at all ones.
  always_comb begin
    if (restart)              elapsed_d = '0;
    else if (&elapsed_q)      elapsed_d = elapsed_q;
    else                      elapsed_d = elapsed_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bpc_pkg::PhIdle;
      dbc_q     <= '0;
      elapsed_q <= '0;
    end else if (item_xfer) begin
      phase_q   <= phase_d;
      dbc_q     <= dbc_d;
      elapsed_q <= elapsed_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic       res_valid_q, res_valid_d;
  logic [1:0] res_event_q;
  logic [3:0] res_phase_q;
  logic       res_changed_q;

  always_comb begin
    res_valid_d = res_valid_q;
    if (item_xfer)           res_valid_d = 1'b1;
    else if (result_o.ready) res_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (item_xfer) begin
      res_event_q   <= event_code;
      res_phase_q   <= phase_d;
      res_changed_q <= (phase_d != phase_q);
    end
  end

  assign result_o.valid         = res_valid_q;
  assign result_o.press_event   = res_event_q;
  assign result_o.phase_code    = res_phase_q;
  assign result_o.phase_changed = res_changed_q;

endmodule
